// ----- sv/volume_and_linear_upsampler_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the volume and linear upsampler
// Implication checks, same cycle and next cycle, under synchronous reset.
// ----------------------------------------------------------------------------
`ifndef VOLUME_AND_LINEAR_UPSAMPLER_ASSERT_SVH
`define VOLUME_AND_LINEAR_UPSAMPLER_ASSERT_SVH

// ante must hold together with cons in the same cycle
`define VLU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vlu check failed: same-cycle implication");

// ante in one cycle must be followed by cons in the next
`define VLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vlu check failed: next-cycle implication");

`endif

// ----- sv/vlu_pkg.sv -----
// ----------------------------------------------------------------------------
// vlu_pkg
// Widths, register map, reset values and shared types of the upsampler.
// ----------------------------------------------------------------------------
package vlu_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int GAIN_W            = 17;
   localparam int FACTOR_W          = 4;
   localparam int REM_W             = FACTOR_W;   // remainder stays below the factor
   localparam int CSR_ADDR_W        = 2;
   localparam int CSR_DATA_W        = GAIN_W;
   localparam int MAX_UP_FACTOR_DEF = 8;

   // register map
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MUTE      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_UP_FACTOR = 2'd2;

   localparam logic [GAIN_W-1:0]   GAIN_RESET     = 17'h10000;
   localparam logic [GAIN_W-1:0]   GAIN_ZERO_MAX  = 17'd65;     // gain*1000 <= 65536
   localparam logic [GAIN_W-1:0]   GAIN_UNITY_MIN = 17'd65471;  // gain*1000 >= 999*65536
   localparam logic [FACTOR_W-1:0] FACTOR_RESET   = 4'd1;
   localparam logic [FACTOR_W-1:0] FACTOR_MIN_INT = 4'd2;       // smallest interpolating factor

   typedef enum logic {
      ALU_DIV,   // one restoring-division step
      ALU_ACC    // quotient/remainder accumulate for the next phase
   } alu_op_type;

   typedef struct packed {
      alu_op_type            op;
      logic [FACTOR_W-1:0]   divisor;
      logic [REM_W-1:0]      rem;
      logic                  shift_bit;
      logic [REM_W-1:0]      acc_r;
      logic [REM_W-1:0]      rd;
      logic [SAMPLE_W-1:0]   acc_q;
      logic [SAMPLE_W-1:0]   qd;
   } alu_req_type;

   typedef struct packed {
      logic [REM_W-1:0]      rem;
      logic                  qbit;
      logic [SAMPLE_W-1:0]   acc_q;
   } alu_rsp_type;

endpackage

// ----- sv/vlu_ifs.sv -----
// ----------------------------------------------------------------------------
// vlu channel interfaces
// Valid/ready channels for input samples, output samples and register writes.
// ----------------------------------------------------------------------------
interface vlu_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [vlu_pkg::SAMPLE_W-1:0]  sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface vlu_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [vlu_pkg::SAMPLE_W-1:0]  sample_out;
   logic                                 last_of_run;

   modport source (output valid, output sample_out, output last_of_run, input ready);
   modport sink   (input valid, input sample_out, input last_of_run, output ready);
endinterface

interface vlu_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [vlu_pkg::CSR_ADDR_W-1:0]       addr;
   logic [vlu_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- sv/vlu_volume.sv -----
// ----------------------------------------------------------------------------
// vlu_volume
// Two-stage software volume: magnitude multiply, then sign and mode select.
// ----------------------------------------------------------------------------
module vlu_volume (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [vlu_pkg::SAMPLE_W-1:0]  sample,
   input  logic [vlu_pkg::GAIN_W-1:0]           gain,
   input  logic                                 mute,
   output logic                                 done,
   output logic signed [vlu_pkg::SAMPLE_W-1:0]  result
);

   localparam int SW     = vlu_pkg::SAMPLE_W;
   localparam int PROD_W = vlu_pkg::SAMPLE_W + vlu_pkg::GAIN_W;
   localparam int FRAC_W = 16;

   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_UNITY,
      MODE_SCALE
   } mode_type;

   logic [SW-1:0]          mag;
   logic [PROD_W-1:0]      prod;
   mode_type               mode;

   logic                   p1_valid_ff;
   mode_type               p1_mode_ff;
   logic                   p1_neg_ff;
   logic [SW-1:0]          p1_mag_ff;
   logic signed [SW-1:0]   p1_sample_ff;
   logic                   done_ff;
   logic signed [SW-1:0]   result_ff;
   logic signed [SW-1:0]   result_in;

   // -32768 negates to 0x8000, which is the right unsigned magnitude
   assign mag  = sample[SW-1] ? SW'(-sample) : SW'(sample);
   assign prod = PROD_W'(mag) * PROD_W'(gain);

   always_comb begin
      if (mute || gain <= vlu_pkg::GAIN_ZERO_MAX) begin
         mode = MODE_ZERO;
      end else if (gain >= vlu_pkg::GAIN_UNITY_MIN) begin
         mode = MODE_UNITY;
      end else begin
         mode = MODE_SCALE;
      end
   end

   always_comb begin
      case (p1_mode_ff)
         MODE_ZERO:  result_in = '0;
         MODE_UNITY: result_in = p1_sample_ff;
         MODE_SCALE: result_in = p1_neg_ff ? $signed(SW'(-p1_mag_ff)) : $signed(p1_mag_ff);
         default:    result_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         p1_valid_ff <= start;
         done_ff     <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_mode_ff   <= mode;
      p1_neg_ff    <= sample[SW-1];
      p1_mag_ff    <= prod[FRAC_W+SW-1:FRAC_W];  // below 32768 for scaling gains
      p1_sample_ff <= sample;
      result_ff    <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ----- sv/vlu_alu.sv -----
// ----------------------------------------------------------------------------
// vlu_alu
// Shared compare/subtract unit: division steps and phase accumulation.
// ----------------------------------------------------------------------------
module vlu_alu (
   input  vlu_pkg::alu_req_type  req,
   output vlu_pkg::alu_rsp_type  rsp
);

   localparam int RW = vlu_pkg::REM_W;

   logic [RW:0]  x;
   logic [RW:0]  x_sub;
   logic         ge;

   always_comb begin
      case (req.op)
         vlu_pkg::ALU_DIV: x = {req.rem, req.shift_bit};
         vlu_pkg::ALU_ACC: x = {1'b0, req.acc_r} + {1'b0, req.rd};
         default:          x = '0;
      endcase
   end

   assign ge    = (x >= {1'b0, req.divisor});
   assign x_sub = x - {1'b0, req.divisor};

   always_comb begin
      rsp.rem   = ge ? x_sub[RW-1:0] : x[RW-1:0];
      rsp.qbit  = ge;
      rsp.acc_q = req.acc_q + req.qd + vlu_pkg::SAMPLE_W'(ge);
   end

endmodule

// ----- sv/volume_and_linear_upsampler.sv -----
// Flow: a new input sample is taken only after the last output beat of the previous
//   run is taken; a run passes the volume pipe, then, for factor F >= 2, the 16-step
//   divider and the emit loop (EMIT_ST, OUT_ST, STEP_ST) around the shared
//   compare/subtract unit.
// Reset: synchronous, active high; gain = unity, mute off, factor 1,
//   previous sample zero, idle and ready.
// ----------------------------------------------------------------------------
// volume_and_linear_upsampler
// Software volume followed by integer-factor linear interpolation.
// ----------------------------------------------------------------------------
module volume_and_linear_upsampler #(
   parameter int MAX_UP_FACTOR = vlu_pkg::MAX_UP_FACTOR_DEF
) (
   input  logic               clock,
   input  logic               reset,
   vlu_req_if.sink            req_ch,
   vlu_rsp_if.source          rsp_ch,
   vlu_csr_if.sink            csr_ch
);

`include "volume_and_linear_upsampler_assert.svh"

   localparam int SW    = vlu_pkg::SAMPLE_W;
   localparam int FW    = vlu_pkg::FACTOR_W;
   localparam int RW    = vlu_pkg::REM_W;
   localparam int CNT_W = $clog2(SW);

   typedef enum logic [2:0] {
      IDLE_ST,   // ready for a sample beat
      VOL_ST,    // wait on the volume pipe, form the difference
      DIV_ST,    // |diff| / factor, one quotient bit per cycle
      EMIT_ST,   // build prev +/- quotient into the output register
      OUT_ST,    // hold the output beat until taken
      STEP_ST    // advance phase k through the shared unit
   } state_type;

   // ---------------------------------------------------------------- config
   logic [vlu_pkg::GAIN_W-1:0]  gain_ff;
   logic                        mute_ff;
   logic [FW-1:0]               factor_ff;
   logic                        factor_ok;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= vlu_pkg::GAIN_RESET;
         mute_ff   <= 1'b0;
         factor_ff <= vlu_pkg::FACTOR_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            vlu_pkg::CSR_GAIN:      gain_ff   <= csr_ch.data;
            vlu_pkg::CSR_MUTE:      mute_ff   <= csr_ch.data[0];
            vlu_pkg::CSR_UP_FACTOR: factor_ff <= csr_ch.data[FW-1:0];
            default:                ;  // unmapped writes dropped
         endcase
      end
   end

   // out-of-range factors fall back to passthrough
   assign factor_ok = (factor_ff >= vlu_pkg::FACTOR_MIN_INT) &&
                      (int'(factor_ff) <= MAX_UP_FACTOR);

   // ---------------------------------------------------------------- volume
   logic                  req_fire;
   logic                  vol_done;
   logic signed [SW-1:0]  vol_result;

   assign req_fire = req_ch.valid && req_ch.ready;

   vlu_volume u_volume (
      .clock  (clock),
      .reset  (reset),
      .start  (req_fire),
      .sample (req_ch.sample_in),
      .gain   (gain_ff),
      .mute   (mute_ff),
      .done   (vol_done),
      .result (vol_result)
   );

   // ---------------------------------------------------------------- control
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]         out_ff, out_in;
   logic                  last_ff, last_in;
   logic [SW-1:0]         prev_ff, prev_in;

   // datapath registers
   logic [SW-1:0]         cur_ff, cur_in;
   logic                  neg_ff, neg_in;
   logic                  pass_ff, pass_in;
   logic [SW-1:0]         div_ff, div_in;      // dividend shifting out, quotient in
   logic [RW-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [FW-1:0]         k_ff, k_in;
   logic [SW-1:0]         acc_q_ff, acc_q_in;
   logic [RW-1:0]         acc_r_ff, acc_r_in;

   logic [SW:0]           diff;
   logic [SW-1:0]         diff_mag;
   logic [SW:0]           interp;
   logic                  is_last_phase;
   logic                  rsp_fire;

   vlu_pkg::alu_req_type  alu_req;
   vlu_pkg::alu_rsp_type  alu_rsp;

   vlu_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign rsp_fire      = rsp_ch.valid && rsp_ch.ready;
   assign diff          = {vol_result[SW-1], vol_result} - {prev_ff[SW-1], prev_ff};
   assign diff_mag      = diff[SW] ? SW'(-diff) : diff[SW-1:0];
   // truncation toward zero: apply the sign of the difference to |diff|*k/F
   assign interp        = {prev_ff[SW-1], prev_ff} +
                          (neg_ff ? (SW+1)'(-{1'b0, acc_q_ff}) : {1'b0, acc_q_ff});
   assign is_last_phase = (k_ff == factor_ff - FW'(1));

   always_comb begin
      alu_req.divisor   = factor_ff;
      alu_req.rem       = rem_ff;
      alu_req.shift_bit = div_ff[SW-1];
      alu_req.acc_r     = acc_r_ff;
      alu_req.rd        = rem_ff;     // remainder of |diff|/F after division
      alu_req.acc_q     = acc_q_ff;
      alu_req.qd        = div_ff;     // quotient of |diff|/F after division
      alu_req.op        = (state_ff == DIV_ST) ? vlu_pkg::ALU_DIV : vlu_pkg::ALU_ACC;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      neg_in       = neg_ff;
      pass_in      = pass_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      acc_q_in     = acc_q_ff;
      acc_r_in     = acc_r_ff;

      case (state_ff)
         IDLE_ST: begin
            if (req_fire) begin
               state_in = VOL_ST;
            end
         end
         VOL_ST: begin
            if (vol_done) begin
               cur_in  = vol_result;
               neg_in  = diff[SW];
               pass_in = !factor_ok;
               if (!factor_ok) begin
                  out_in       = vol_result;
                  last_in      = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = OUT_ST;
               end else begin
                  div_in   = diff_mag;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = DIV_ST;
               end
            end
         end
         DIV_ST: begin
            div_in = {div_ff[SW-2:0], alu_rsp.qbit};
            rem_in = alu_rsp.rem;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SW - 1)) begin
               k_in     = '0;
               acc_q_in = '0;
               acc_r_in = '0;
               state_in = EMIT_ST;
            end
         end
         EMIT_ST: begin
            out_in       = interp[SW-1:0];
            last_in      = is_last_phase;
            rsp_valid_in = 1'b1;
            state_in     = OUT_ST;
         end
         OUT_ST: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  if (!pass_ff) begin
                     prev_in = cur_ff;
                  end
                  state_in = IDLE_ST;
               end else begin
                  state_in = STEP_ST;
               end
            end
         end
         STEP_ST: begin
            acc_q_in = alu_rsp.acc_q;
            acc_r_in = alu_rsp.rem;
            k_in     = k_ff + FW'(1);
            state_in = EMIT_ST;
         end
         default: begin
            state_in = IDLE_ST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_ST;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
      end
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      neg_ff   <= neg_in;
      pass_ff  <= pass_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      k_ff     <= k_in;
      acc_q_ff <= acc_q_in;
      acc_r_ff <= acc_r_in;
   end

   assign req_ch.ready       = (state_ff == IDLE_ST);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.sample_out  = $signed(out_ff);
   assign rsp_ch.last_of_run = last_ff;

   // ---------------------------------------------------------------- checks
   // no new sample while an output beat is pending
   `VLU_ASSERT_IMPLY(a_busy_while_out, clock, reset, rsp_ch.valid, !req_ch.ready)
   // the final beat of a run frees the input side right away
   `VLU_ASSERT_NEXT(a_ready_after_last, clock, reset, rsp_fire && rsp_ch.last_of_run,
                    req_ch.ready)
   // phase remainder always below the factor
   `VLU_ASSERT_IMPLY(a_rem_bound, clock, reset, state_ff == EMIT_ST, acc_r_ff < factor_ff)
   // passthrough runs are a single beat
   `VLU_ASSERT_IMPLY(a_pass_single, clock, reset, rsp_ch.valid && pass_ff,
                     rsp_ch.last_of_run)

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: volume and linear upsampler testbench
// Directed tests for the gain thresholds, factor limits and interpolation
// extremes, then randomized phases of samples under changing settings.
// Every output beat is checked against an in-bench prediction of the block.
// ----------------------------------------------------------------------------
module tb;

   localparam int SAMPLE_W          = vlu_pkg::SAMPLE_W;
   localparam int GAIN_W            = vlu_pkg::GAIN_W;
   localparam int FACTOR_W          = vlu_pkg::FACTOR_W;
   localparam int CSR_ADDR_W        = vlu_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W        = vlu_pkg::CSR_DATA_W;
   localparam int MAX_UP_FACTOR_DEF = vlu_pkg::MAX_UP_FACTOR_DEF;

   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN      = vlu_pkg::CSR_GAIN;
   localparam logic [CSR_ADDR_W-1:0] CSR_MUTE      = vlu_pkg::CSR_MUTE;
   localparam logic [CSR_ADDR_W-1:0] CSR_UP_FACTOR = vlu_pkg::CSR_UP_FACTOR;

   localparam logic [GAIN_W-1:0]   GAIN_RESET     = vlu_pkg::GAIN_RESET;
   localparam logic [GAIN_W-1:0]   GAIN_ZERO_MAX  = vlu_pkg::GAIN_ZERO_MAX;
   localparam logic [GAIN_W-1:0]   GAIN_UNITY_MIN = vlu_pkg::GAIN_UNITY_MIN;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET   = vlu_pkg::FACTOR_RESET;
   localparam logic [FACTOR_W-1:0] FACTOR_MIN_INT = vlu_pkg::FACTOR_MIN_INT;

   // index past the end of the register map; writes to it must be ignored
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_WAIT  = 24;
   localparam int END_WAIT     = 40;
   localparam int IDLE_MAX     = 18;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 30;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } out_beat_type;

   logic clock;
   logic reset;

   vlu_req_if req_bus ();
   vlu_rsp_if rsp_bus ();
   vlu_csr_if csr_bus ();

   volume_and_linear_upsampler u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // shadow of the block: settings and the held interpolation start point
   logic [GAIN_W-1:0]   cfg_gain;
   logic                cfg_mute;
   logic [FACTOR_W-1:0] cfg_factor;
   int                  held_sample;

   out_beat_type expected_beats [$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           idle_max    = IDLE_MAX;  // 0 gives a stretch with no idling

   // ------------------------------------------------------------------
   // clock and run limit
   // ------------------------------------------------------------------
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------
   // software volume: zero at or below the low threshold or on mute, unity at or
   // above the high one (gains past unity saturate), else scale toward zero
   function automatic logic signed [SAMPLE_W-1:0] scale_by_gain(
      input logic signed [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] mag;
      logic [32:0]         prod;
      logic [SAMPLE_W-1:0] scaled;
      if (cfg_mute || cfg_gain <= GAIN_ZERO_MAX)
         return '0;
      if (cfg_gain >= GAIN_UNITY_MIN)
         return s;
      mag    = s[SAMPLE_W-1] ? SAMPLE_W'(-s) : SAMPLE_W'(s);  // -32768 -> 0x8000
      prod   = mag * cfg_gain;
      scaled = prod[31:16];
      return s[SAMPLE_W-1] ? -scaled : scaled;
   endfunction

   // append one beat to the expected list
   task automatic queue_beat(input out_beat_type b);
      expected_beats.insert(expected_beats.size(), b);
   endtask

   // queue the beats one input sample causes
   task automatic queue_interpolated(input logic signed [SAMPLE_W-1:0] s);
      int           cur;
      int           up;
      int           diff;
      out_beat_type b;
      cur = scale_by_gain(s);
      up  = cfg_factor;
      if (up <= 1 || up > MAX_UP_FACTOR_DEF) begin
         // passthrough: one beat, held sample left alone
         b.sample = cur[SAMPLE_W-1:0];
         b.last   = 1'b1;
         queue_beat(b);
      end else begin
         diff = cur - held_sample;
         for (int k = 0; k < up; k++) begin
            b.sample = SAMPLE_W'(held_sample + (diff * k) / up);  // / truncates to zero
            b.last   = (k == up - 1);
            queue_beat(b);
         end
         held_sample = cur;
      end
   endtask

   // ------------------------------------------------------------------
   // mismatch report
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (error_count < 100)
         $display("[cycle %0d] error: %s", cycle_count, msg);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // output side: random stall per beat, then check against the oldest
   // ------------------------------------------------------------------
   initial begin : rsp_checker
      out_beat_type want;
      int           stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = $urandom_range(0, idle_max);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat sample=%0d last=%b",
                                      rsp_bus.sample_out, rsp_bus.last_of_run));
         end else begin
            want = expected_beats.pop_front();
            if (rsp_bus.sample_out !== want.sample)
               report_mismatch($sformatf("sample_out got %0d expected %0d",
                                         rsp_bus.sample_out,
                                         $signed(want.sample)));
            if (rsp_bus.last_of_run !== want.last)
               report_mismatch($sformatf("last_of_run got %b expected %b",
                                         rsp_bus.last_of_run, want.last));
         end
      end
   end

   // ------------------------------------------------------------------
   // input side
   // ------------------------------------------------------------------
   // valid stays up across back-to-back beats; it drops only for a gap
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= s;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      queue_interpolated(s);
   endtask

   // stop sending, let every expected beat arrive, then let the block go idle
   task automatic drain_outputs();
      req_bus.valid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // one register write; valid is left high so writes can go back to back
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_GAIN:      cfg_gain   = val[GAIN_W-1:0];
         CSR_MUTE:      cfg_mute   = val[0];
         CSR_UP_FACTOR: cfg_factor = val[FACTOR_W-1:0];
         default: ;
      endcase
   endtask

   // unused upper bits of mute and factor writes carry random junk
   task automatic apply_settings(input logic [GAIN_W-1:0]   g,
                                 input logic                m,
                                 input logic [FACTOR_W-1:0] f);
      logic [CSR_DATA_W-1:0] val;
      drain_outputs();
      write_reg(CSR_GAIN, g);
      val    = CSR_DATA_W'($urandom);
      val[0] = m;
      write_reg(CSR_MUTE, val);
      val                = CSR_DATA_W'($urandom);
      val[FACTOR_W-1:0]  = f;
      write_reg(CSR_UP_FACTOR, val);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // thresholds and saturation points get extra weight
   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return GAIN_ZERO_MAX;
         2:       return GAIN_W'(GAIN_ZERO_MAX + 1);
         3:       return GAIN_W'(GAIN_UNITY_MIN - 1);
         4:       return GAIN_UNITY_MIN;
         5:       return GAIN_RESET;
         6:       return 17'h1ffff;
         default: return GAIN_W'($urandom_range(0, 131071));
      endcase
   endfunction

   function automatic logic [FACTOR_W-1:0] pick_factor();
      if ($urandom_range(0, 5) == 0)
         return FACTOR_W'($urandom_range(0, 15));  // may be out of range
      return FACTOR_W'($urandom_range(1, MAX_UP_FACTOR_DEF));
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // reset settings: unity gain, factor 1, so samples pass straight through
   task automatic test_reset_passthrough();
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(16'sh0000);
      send_sample(16'shffff);
   endtask

   // both volume thresholds from each side, gain past unity, mute
   task automatic test_gain_thresholds();
      apply_settings(GAIN_ZERO_MAX, 1'b0, FACTOR_RESET);
      send_sample(16'sh7fff);
      apply_settings(GAIN_W'(GAIN_ZERO_MAX + 1), 1'b0, FACTOR_RESET);
      send_sample(16'sh8000);
      apply_settings(GAIN_W'(GAIN_UNITY_MIN - 1), 1'b0, FACTOR_RESET);
      send_sample(16'sh8000);
      apply_settings(GAIN_UNITY_MIN, 1'b0, FACTOR_RESET);
      send_sample(16'sh7fff);
      apply_settings(17'h1ffff, 1'b0, FACTOR_RESET);
      send_sample(16'sh8001);
      apply_settings(17'h08000, 1'b0, FACTOR_RESET);
      send_sample(-16'sd3);
      apply_settings(GAIN_RESET, 1'b1, FACTOR_RESET);
      send_sample(16'sh7fff);
   endtask

   // full-swing steps at the largest and smallest factors, out-of-range
   // factors, and a muted sample that still becomes the held sample
   task automatic test_interpolation();
      apply_settings(GAIN_RESET, 1'b0, FACTOR_W'(MAX_UP_FACTOR_DEF));
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      apply_settings(GAIN_RESET, 1'b0, FACTOR_MIN_INT);
      send_sample(16'sh7fff);
      apply_settings(GAIN_RESET, 1'b0, 4'd0);
      send_sample(16'sh1234);
      apply_settings(GAIN_RESET, 1'b0, FACTOR_W'(MAX_UP_FACTOR_DEF + 1));
      send_sample(16'sh8000);
      apply_settings(GAIN_RESET, 1'b0, 4'd15);
      send_sample(16'sh4321);
      apply_settings(GAIN_RESET, 1'b1, 4'd3);
      send_sample(16'sh7fff);
   endtask

   // a factor-1 beat in between must not move the interpolation start
   task automatic test_passthrough_keeps_held();
      apply_settings(GAIN_RESET, 1'b0, 4'd4);
      send_sample(16'sh2000);
      apply_settings(GAIN_RESET, 1'b0, FACTOR_RESET);
      send_sample(16'sh8000);
      apply_settings(GAIN_RESET, 1'b0, 4'd4);
      send_sample(-16'sd4000);
   endtask

   // a write past the register map changes nothing
   task automatic test_spare_index();
      apply_settings(17'h0c000, 1'b0, 4'd5);
      @(posedge clock);
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_bus.valid <= 1'b0;
      send_sample(16'sh7fff);
   endtask

   // random settings per phase, random samples, idling varies per phase;
   // one phase pauses halfway until every expected beat is out
   task automatic test_random_phases();
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 3))
            0:       idle_max = 0;
            1:       idle_max = 4;
            default: idle_max = IDLE_MAX;
         endcase
         apply_settings(pick_gain(), ($urandom_range(0, 5) == 0), pick_factor());
         if ($urandom_range(0, 3) == 0) begin
            @(posedge clock);
            write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
            csr_bus.valid <= 1'b0;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == PHASES / 2 && i == PHASE_ITEMS / 2)
               drain_outputs();
            send_sample(pick_sample());
         end
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.sample_in <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.addr      <= CSR_GAIN;
      csr_bus.data      <= '0;
      cfg_gain          = GAIN_RESET;
      cfg_mute          = 1'b0;
      cfg_factor        = FACTOR_RESET;
      held_sample       = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_passthrough();
      test_gain_thresholds();
      test_interpolation();
      test_passthrough_keeps_held();
      test_spare_index();
      test_random_phases();

      idle_max = 0;
      req_bus.valid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (END_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
